### design/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

  // Number of cells in the chain, and width of a stored priority
  localparam int unsigned DEPTH     = 8;
  localparam int unsigned PRIO_BITS = 8;

  // Port field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned STATUS_W = 2;

  typedef logic [PRIO_BITS-1:0] prio_t;

  // Command codes on the cmd field
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One queue entry as held by a cell
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    prio_t                    prio;
  } entry_t;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic  enq;
    logic  deq;
    prio_t new_prio;
  } cell_ctrl_t;

endpackage

### design/spq_if.sv
// Handshake channels for queue commands and queue results.
interface spq_in_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] item_data;
  logic [PRIO_W-1:0]        item_priority;

  modport source (output valid, cmd, item_data, item_priority, input ready);
  modport sink   (input valid, cmd, item_data, item_priority, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] out_data;
  logic [PRIO_W-1:0]        out_priority;

  modport source (output valid, status, out_data, out_priority, input ready);
  modport sink   (input valid, status, out_data, out_priority, output ready);
endinterface

### design/spq_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t     new_i,
  input  spq_pkg::entry_t     left_i,
  input  logic                left_keep_i,
  input  spq_pkg::entry_t     right_i,
  output spq_pkg::entry_t     entry_o,
  output logic                keep_o
);
  import spq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  // Entry stays put on insert when it ranks equal or above the newcomer
  assign keep_o = valid_q && (entry_q.prio >= ctrl_i.new_prio);

  // Next entry: hold, take the newcomer, shift right on insert, shift left on removal
  always_comb begin
    entry_d       = entry_q;
    entry_d.valid = valid_q;
    if (ctrl_i.enq) begin
      if (keep_o) begin
        entry_d.valid = valid_q;
      end else if (left_keep_i) begin
        entry_d = new_i;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
    valid_d = entry_d.valid;
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_comb begin
    entry_o       = entry_q;
    entry_o.valid = valid_q;
  end

endmodule

### design/sorted_priority_queue_top.sv
// Sorted priority queue built as a shifting chain of cells.
// The queue holds up to DEPTH entries in a row of cells ordered by priority, highest at
// the head. Each command item (enqueue or dequeue) gives exactly one result item; one
// item is taken every clock cycle while no result waits, since every cell compares
// itself against the incoming priority and shifts with its neighbors in the same
// cycle, so an insert or a removal completes in one step. The result appears on the
// output channel in the cycle after the command is accepted and is held in an output
// register; a new command is taken while that register is empty or being drained.
// An enqueue lands behind all entries of equal or higher priority, so equal priorities
// leave in arrival order; an enqueue into a full queue is dropped with status full, a
// dequeue from an empty queue returns status empty with zero data and priority. Reset empties the queue at once.
module sorted_priority_queue_top (
  input logic     clk_i,
  input logic     rst_ni,
  spq_in_if.sink  req_i,
  spq_out_if.source rsp_o
);
  import spq_pkg::*;

  entry_t           cells [DEPTH];
  logic [DEPTH-1:0] keep;
  logic [DEPTH-1:0] occ;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;

  logic accept, full, empty, do_enq, do_deq;

  logic                     out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]      status_q, status_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [PRIO_W-1:0]        prio_q, prio_d;

  // Handshake and queue condition
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = occ[DEPTH-1];
  assign empty       = !occ[0];
  assign do_enq      = accept && (req_i.cmd == CMD_ENQ) && !full;
  assign do_deq      = accept && (req_i.cmd == CMD_DEQ) && !empty;

  // Broadcast to the chain
  always_comb begin
    ctrl.enq            = do_enq;
    ctrl.deq            = do_deq;
    ctrl.new_prio       = prio_t'(req_i.item_priority);
    new_entry.valid     = 1'b1;
    new_entry.data      = req_i.item_data;
    new_entry.prio      = prio_t'(req_i.item_priority);
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_keep;

    if (i == 0) begin : g_head
      assign left_e    = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_e    = cells[i-1];
      assign left_keep = keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_i      (new_entry),
      .left_i     (left_e),
      .left_keep_i(left_keep),
      .right_i    (right_e),
      .entry_o    (cells[i]),
      .keep_o     (keep[i])
    );

    assign occ[i] = cells[i].valid;
  end

  // Result for the accepted item
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    data_d      = data_q;
    prio_d      = prio_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      data_d      = '0;
      prio_d      = '0;
      if (req_i.cmd == CMD_ENQ) begin
        status_d = full ? ST_FULL : ST_DONE;
      end else if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_DONE;
        data_d   = cells[0].data;
        prio_d   = PRIO_W'(cells[0].prio);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    prio_q   <= prio_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_data     = data_q;
  assign rsp_o.out_priority = prio_q;

  // Chain order check: occupied cells ranked highest first
  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int unsigned k = 0; k + 1 < DEPTH; k++) begin
      if (cells[k+1].valid && (cells[k].prio < cells[k+1].prio)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  // Occupied cells form an unbroken run from the head
  a_occ_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ & (occ + DEPTH'(1))) == '0)
    else $error("queue occupancy has a gap");

  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni) sorted_ok)
    else $error("queue entries out of priority order");

  // A dequeue on a non-empty queue returns the old head
  a_deq_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_deq |=> rsp_o.valid && (rsp_o.status == ST_DONE)
               && (rsp_o.out_data == $past(cells[0].data)))
    else $error("dequeue did not return the head entry");

  // A waiting result blocks new items
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("item accepted while result waits");

endmodule
